FILE: rtl/sll_pkg.sv
// ----------------------------------------------------------------------------
// sll_pkg
// Shared widths, command codes and the controller/datapath command and status
// structs of the static linked list engine.
// ----------------------------------------------------------------------------
package sll_pkg;

  localparam int DATA_W = 32;
  localparam int POS_W  = 6;
  localparam int CNT_W  = 6;
  localparam int CMD_W  = 2;

  // command codes carried in the input tuser
  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT   = 2'd0,
    CMD_DELETE   = 2'd1,
    CMD_TRAVERSE = 2'd2
  } cmd_e_t;

  // link memory read address source
  typedef enum logic [1:0] {
    RD_FREE = 2'd0,  // free list head
    RD_HEAD = 2'd1,  // data list head
    RD_LINK = 2'd2   // link just read
  } rd_sel_t;

  // link memory write address source
  typedef enum logic [1:0] {
    WA_FREE  = 2'd0,
    WA_FRESH = 2'd1,
    WA_CUR   = 2'd2
  } wa_sel_t;

  // link memory write data source
  typedef enum logic {
    WD_LINK  = 1'b0,
    WD_FRESH = 1'b1
  } wd_sel_t;

  // kind of result loaded into the output register
  typedef enum logic [1:0] {
    OK_DONE  = 2'd0,
    OK_ERR   = 2'd1,
    OK_EMPTY = 2'd2,
    OK_ELEM  = 2'd3
  } out_kind_t;

  typedef struct packed {
    logic      load_in;
    logic      rd_en;
    rd_sel_t   rd_sel;
    logic      wr_en;
    wa_sel_t   wa_sel;
    wd_sel_t   wd_sel;
    logic      val_wr;
    logic      val_rd;
    logic      fresh_ld;
    logic      walk_start;
    logic      walk_step;
    logic      trav_start;
    logic      cnt_inc;
    logic      cnt_dec;
    logic      emit;
    out_kind_t out_kind;
  } dp_cmd_t;

  typedef struct packed {
    logic ins_bad;
    logic del_bad;
    logic cnt_zero;
    logic rem_zero;
    logic link_zero;
    logic fin;
    logic out_free;
  } dp_sts_t;

endpackage

FILE: rtl/static_linked_list_engine_top.sv
// ----------------------------------------------------------------------------
// static_linked_list_engine_top
// Cursor-array linked list: insert before a position, delete at a position,
// traverse in order, with an error status and the element count per result.
// ----------------------------------------------------------------------------
//
//  channel   ports                          direction  items
//  --------  -----------------------------  ---------  -----------------------
//  in        in_tvalid/in_tready/in_tdata/  slave      one command
//            in_tuser
//  out       out_tvalid/out_tready/         master     one result (traverse:
//            out_tdata/out_tlast                       one per element)
//
//  flow: insert and delete walk the link chain up to the position, one link
//  memory read per step; traverse sends one element per cycle while the
//  output is taken; a rejected command goes straight to its response.
//  reset: rst_n synchronous active low; the link array's reset image comes
//  from per-entry valid bits, so the block takes commands right after reset.
//  stalls: the output register lets a command be accepted while a result
//  waits; a traverse holds its walk while out_tready is low.
// ----------------------------------------------------------------------------
module static_linked_list_engine_top #(
  parameter int NODES = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  // command channel
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // position[5:0], value[37:6], zero pad[39:38]
  input  logic [1:0]  in_tuser,   // cmd[1:0]
  // result channel
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // status[0], elem[32:1], is_empty[33], count[39:34]
  output logic        out_tlast   // last result of the item
);
  import sll_pkg::*;

  dp_cmd_t           dp_cmd;
  dp_sts_t           dp_sts;
  logic              res_status;
  logic [DATA_W-1:0] res_elem;
  logic              res_empty;
  logic [CNT_W-1:0]  res_count;

  // controller: walks the command through its steps
  sll_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_cmd    (in_tuser),
    .cmd       (dp_cmd),
    .sts       (dp_sts)
  );

  // datapath: memories, cursor, count and the output register
  sll_dp #(
    .NODES (NODES)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_position  (in_tdata[5:0]),
    .in_value     (in_tdata[37:6]),
    .cmd          (dp_cmd),
    .sts          (dp_sts),
    .out_tready   (out_tready),
    .out_tvalid   (out_tvalid),
    .out_status   (res_status),
    .out_elem     (res_elem),
    .out_is_empty (res_empty),
    .out_last     (out_tlast),
    .out_count    (res_count)
  );

  // pack the result fields, highest field first
  assign out_tdata = {res_count, res_empty, res_elem, res_status};

endmodule

FILE: rtl/sll_dp.sv
// ----------------------------------------------------------------------------
// sll_dp
// Datapath: link and value memories, walk cursor, element count and the
// output result register.
// ----------------------------------------------------------------------------
module sll_dp #(
  parameter int NODES = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [sll_pkg::POS_W-1:0]     in_position,
  input  logic [sll_pkg::DATA_W-1:0]    in_value,
  input  sll_pkg::dp_cmd_t              cmd,
  output sll_pkg::dp_sts_t              sts,
  input  logic                          out_tready,
  output logic                          out_tvalid,
  output logic                          out_status,
  output logic [sll_pkg::DATA_W-1:0]    out_elem,
  output logic                          out_is_empty,
  output logic                          out_last,
  output logic [sll_pkg::CNT_W-1:0]     out_count
);
  import sll_pkg::*;

  localparam int              NW   = $clog2(NODES);
  localparam logic [NW-1:0]   HEAD = NW'(NODES - 1);
  localparam logic [CNT_W-1:0] CAP = CNT_W'(NODES - 2);

  // reset image of the link array: free chain 1..NODES-2, data head ends at once
  function automatic logic [NW-1:0] rst_link(input logic [NW-1:0] a);
    logic [NW-1:0] r;
    r = '0;
    if (int'(a) < NODES - 2) begin
      r = a + NW'(1);
    end
    return r;
  endfunction

  logic [NW-1:0]     link_mem [NODES];
  logic [NODES-1:0]  link_vld_r;
  logic [NW-1:0]     link_rdata_r;
  logic [NW-1:0]     link_raddr_r;
  logic              link_rvld_r;
  logic [NW-1:0]     link_q;

  logic [DATA_W-1:0] val_mem [NODES];
  logic [DATA_W-1:0] val_q_r;

  logic [DATA_W-1:0] val_r;
  logic [POS_W-1:0]  pos_r;
  logic [NW-1:0]     cur_r;
  logic [NW-1:0]     fresh_r;
  logic [POS_W-1:0]  rem_r;
  logic [CNT_W-1:0]  n_r;
  logic [CNT_W-1:0]  count_r;

  logic [NW-1:0]     rd_addr;
  logic [NW-1:0]     wr_addr;
  logic [NW-1:0]     wr_data;

  logic              out_valid_r;
  logic              out_status_r;
  logic [DATA_W-1:0] out_elem_r;
  logic              out_empty_r;
  logic              out_last_r;
  logic [CNT_W-1:0]  out_count_r;

  // entries never written read back as their reset image
  assign link_q = link_rvld_r ? link_rdata_r : rst_link(link_raddr_r);

  always_comb begin
    unique case (cmd.rd_sel)
      RD_FREE: rd_addr = '0;
      RD_HEAD: rd_addr = HEAD;
      RD_LINK: rd_addr = link_q;
      default: rd_addr = '0;
    endcase
    unique case (cmd.wa_sel)
      WA_FREE:  wr_addr = '0;
      WA_FRESH: wr_addr = fresh_r;
      WA_CUR:   wr_addr = cur_r;
      default:  wr_addr = '0;
    endcase
    wr_data = (cmd.wd_sel == WD_FRESH) ? fresh_r : link_q;
  end

  // link memory with registered read
  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      link_mem[wr_addr] <= wr_data;
    end
    if (cmd.rd_en) begin
      link_rdata_r <= link_mem[rd_addr];
      link_raddr_r <= rd_addr;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      link_vld_r  <= '0;
      link_rvld_r <= 1'b0;
    end else begin
      if (cmd.wr_en) begin
        link_vld_r[wr_addr] <= 1'b1;
      end
      if (cmd.rd_en) begin
        link_rvld_r <= link_vld_r[rd_addr];
      end
    end
  end

  // value memory, addressed by the link just read
  always_ff @(posedge clk) begin
    if (cmd.val_wr) begin
      val_mem[link_q] <= val_r;
    end
    if (cmd.val_rd) begin
      val_q_r <= val_mem[link_q];
    end
  end

  // item latch and walk cursor
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      val_r <= in_value;
      pos_r <= in_position;
    end
    if (cmd.fresh_ld) begin
      fresh_r <= link_q;
    end
    if (cmd.walk_start) begin
      cur_r <= HEAD;
      rem_r <= pos_r - POS_W'(1);
    end else if (cmd.walk_step) begin
      cur_r <= link_q;
      rem_r <= rem_r - POS_W'(1);
    end
    if (cmd.trav_start) begin
      n_r <= '0;
    end else if (cmd.emit && cmd.out_kind == OK_ELEM) begin
      n_r <= n_r + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (cmd.cnt_inc) begin
      count_r <= count_r + CNT_W'(1);
    end else if (cmd.cnt_dec) begin
      count_r <= count_r - CNT_W'(1);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_count_r <= count_r;
      unique case (cmd.out_kind)
        OK_DONE: begin
          out_status_r <= 1'b0;
          out_elem_r   <= '0;
          out_empty_r  <= 1'b0;
          out_last_r   <= 1'b1;
        end
        OK_ERR: begin
          out_status_r <= 1'b1;
          out_elem_r   <= '0;
          out_empty_r  <= 1'b0;
          out_last_r   <= 1'b1;
        end
        OK_EMPTY: begin
          out_status_r <= 1'b0;
          out_elem_r   <= '0;
          out_empty_r  <= 1'b1;
          out_last_r   <= 1'b1;
        end
        OK_ELEM: begin
          out_status_r <= 1'b0;
          out_elem_r   <= val_q_r;
          out_empty_r  <= 1'b0;
          out_last_r   <= sts.fin;
        end
        default: begin
          out_status_r <= 1'b1;
          out_elem_r   <= '0;
          out_empty_r  <= 1'b0;
          out_last_r   <= 1'b1;
        end
      endcase
    end
  end

  assign out_tvalid   = out_valid_r;
  assign out_status   = out_status_r;
  assign out_elem     = out_elem_r;
  assign out_is_empty = out_empty_r;
  assign out_last     = out_last_r;
  assign out_count    = out_count_r;

  // status back to the controller
  always_comb begin
    sts.ins_bad   = (in_position == '0)
                  || ({1'b0, in_position} > ({1'b0, count_r} + 7'd1))
                  || (count_r >= CAP);
    sts.del_bad   = (in_position == '0) || (in_position > count_r);
    sts.cnt_zero  = (count_r == '0);
    sts.rem_zero  = (rem_r == '0);
    sts.link_zero = (link_q == '0);
    sts.fin       = (link_q == '0) || (({1'b0, n_r} + 7'd1) >= {1'b0, count_r});
    sts.out_free  = !out_valid_r || out_tready;
  end

  a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CAP) else $error("element count above capacity");

  a_inc_room: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.cnt_inc |-> count_r < CAP) else $error("insert into full store");

  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> (!out_valid_r || out_tready))
    else $error("result overwrites unread result");

endmodule

FILE: rtl/sll_ctrl.sv
// ----------------------------------------------------------------------------
// sll_ctrl
// Controller: sequences insert, delete and traverse over the datapath.
// ----------------------------------------------------------------------------
module sll_ctrl (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [sll_pkg::CMD_W-1:0]   in_cmd,
  output sll_pkg::dp_cmd_t            cmd,
  input  sll_pkg::dp_sts_t            sts
);
  import sll_pkg::*;

  typedef enum logic [12:0] {
    S_IDLE     = 13'b0000000000001,
    S_I_FRESH  = 13'b0000000000010,
    S_I_POP    = 13'b0000000000100,
    S_I_UNLINK = 13'b0000000001000,
    S_D_START  = 13'b0000000010000,
    S_WALK     = 13'b0000000100000,
    S_I_LINK   = 13'b0000001000000,
    S_D_READ   = 13'b0000010000000,
    S_D_FREE   = 13'b0000100000000,
    S_D_HEAD   = 13'b0001000000000,
    S_T_START  = 13'b0010000000000,
    S_T_FIRST  = 13'b0100000000000,
    S_RESP     = 13'b1000000000000
  } state_t;

  // traverse emits from the S_T_FIRST state code, which this alias names
  localparam state_t S_T_EMIT_ALIAS = S_T_FIRST;

  typedef enum logic [1:0] {
    P_WALK = 2'd0,
    P_EMIT = 2'd1
  } tphase_t;

  state_t    state_r, state_nxt;
  tphase_t   tph_r, tph_nxt;
  logic      is_ins_r, is_ins_nxt;
  out_kind_t kind_r, kind_nxt;
  logic      accept;

  assign in_tready = (state_r == S_IDLE);
  assign accept    = in_tvalid && in_tready;

  always_comb begin
    cmd        = '0;
    cmd.rd_sel = RD_LINK;
    cmd.wa_sel = WA_FREE;
    cmd.wd_sel = WD_LINK;
    cmd.out_kind = kind_r;
    state_nxt  = state_r;
    tph_nxt    = tph_r;
    is_ins_nxt = is_ins_r;
    kind_nxt   = kind_r;

    unique case (state_r)
      S_IDLE: begin
        tph_nxt = P_WALK;
        if (accept) begin
          cmd.load_in = 1'b1;
          unique case (cmd_e_t'(in_cmd))
            CMD_INSERT: begin
              is_ins_nxt = 1'b1;
              if (sts.ins_bad) begin
                kind_nxt  = OK_ERR;
                state_nxt = S_RESP;
              end else begin
                state_nxt = S_I_FRESH;
              end
            end
            CMD_DELETE: begin
              is_ins_nxt = 1'b0;
              if (sts.del_bad) begin
                kind_nxt  = OK_ERR;
                state_nxt = S_RESP;
              end else begin
                state_nxt = S_D_START;
              end
            end
            CMD_TRAVERSE: begin
              if (sts.cnt_zero) begin
                kind_nxt  = OK_EMPTY;
                state_nxt = S_RESP;
              end else begin
                state_nxt = S_T_START;
              end
            end
            default: begin
              kind_nxt  = OK_ERR;
              state_nxt = S_RESP;
            end
          endcase
        end
      end
      S_I_FRESH: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = RD_FREE;
        state_nxt  = S_I_POP;
      end
      S_I_POP: begin
        cmd.fresh_ld = 1'b1;
        cmd.val_wr   = 1'b1;
        cmd.rd_en    = 1'b1;
        cmd.rd_sel   = RD_LINK;
        state_nxt    = S_I_UNLINK;
      end
      S_I_UNLINK: begin
        cmd.wr_en      = 1'b1;
        cmd.wa_sel     = WA_FREE;
        cmd.wd_sel     = WD_LINK;
        cmd.rd_en      = 1'b1;
        cmd.rd_sel     = RD_HEAD;
        cmd.walk_start = 1'b1;
        state_nxt      = S_WALK;
      end
      S_D_START: begin
        cmd.rd_en      = 1'b1;
        cmd.rd_sel     = RD_HEAD;
        cmd.walk_start = 1'b1;
        state_nxt      = S_WALK;
      end
      S_WALK: begin
        if (!sts.rem_zero) begin
          cmd.walk_step = 1'b1;
          cmd.rd_en     = 1'b1;
          cmd.rd_sel    = RD_LINK;
        end else if (is_ins_r) begin
          // fresh node takes over the link of its predecessor
          cmd.wr_en  = 1'b1;
          cmd.wa_sel = WA_FRESH;
          cmd.wd_sel = WD_LINK;
          state_nxt  = S_I_LINK;
        end else begin
          cmd.fresh_ld = 1'b1;
          cmd.rd_en    = 1'b1;
          cmd.rd_sel   = RD_LINK;
          state_nxt    = S_D_READ;
        end
      end
      S_I_LINK: begin
        cmd.wr_en   = 1'b1;
        cmd.wa_sel  = WA_CUR;
        cmd.wd_sel  = WD_FRESH;
        cmd.cnt_inc = 1'b1;
        kind_nxt    = OK_DONE;
        state_nxt   = S_RESP;
      end
      S_D_READ: begin
        cmd.wr_en  = 1'b1;
        cmd.wa_sel = WA_CUR;
        cmd.wd_sel = WD_LINK;
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = RD_FREE;
        state_nxt  = S_D_FREE;
      end
      S_D_FREE: begin
        cmd.wr_en  = 1'b1;
        cmd.wa_sel = WA_FRESH;
        cmd.wd_sel = WD_LINK;
        state_nxt  = S_D_HEAD;
      end
      S_D_HEAD: begin
        cmd.wr_en   = 1'b1;
        cmd.wa_sel  = WA_FREE;
        cmd.wd_sel  = WD_FRESH;
        cmd.cnt_dec = 1'b1;
        kind_nxt    = OK_DONE;
        state_nxt   = S_RESP;
      end
      S_T_START: begin
        cmd.rd_en      = 1'b1;
        cmd.rd_sel     = RD_HEAD;
        cmd.trav_start = 1'b1;
        tph_nxt        = P_WALK;
        state_nxt      = S_T_FIRST;
      end
      S_T_FIRST: begin
        cmd.out_kind = OK_ELEM;
        if (tph_r == P_WALK) begin
          // first element: fetch its value and link
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RD_LINK;
          cmd.val_rd = 1'b1;
          tph_nxt    = P_EMIT;
        end else if (sts.out_free) begin
          cmd.emit = 1'b1;
          if (sts.fin) begin
            state_nxt = S_IDLE;
          end else begin
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = RD_LINK;
            cmd.val_rd = 1'b1;
          end
        end
      end
      S_RESP: begin
        if (sts.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      tph_r    <= P_WALK;
      is_ins_r <= 1'b0;
      kind_r   <= OK_DONE;
    end else begin
      state_r  <= state_nxt;
      tph_r    <= tph_nxt;
      is_ins_r <= is_ins_nxt;
      kind_r   <= kind_nxt;
    end
  end

  a_bad_insert: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_cmd == CMD_INSERT && sts.ins_bad) |=> state_r == S_RESP)
    else $error("rejected insert did not go straight to response");

  a_walk_chain: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WALK && !sts.rem_zero) |-> !sts.link_zero)
    else $error("walk ran off the end of the data chain");

  a_trav_emit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_T_EMIT_ALIAS && cmd.emit) |-> cmd.out_kind == OK_ELEM)
    else $error("traverse emitted a non-element result");

endmodule

FILE: sim/sll_checker.sv
// ----------------------------------------------------------------------------
// sll_checker
// Watches both streams of the linked list engine, keeps its own copy of the
// node array and compares every result with the oldest one it predicted.
// ----------------------------------------------------------------------------
module sll_checker #(
  parameter int NODES = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [39:0] in_tdata,   // position[5:0], value[37:6], zero pad[39:38]
  input  logic [1:0]  in_tuser,   // cmd[1:0]
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [39:0] out_tdata,  // status[0], elem[32:1], is_empty[33], count[39:34]
  input  logic        out_tlast,
  output int          fail_count,
  output int          pending
);
  import sll_pkg::*;

  localparam int HEAD     = NODES - 1;
  localparam int CAPACITY = NODES - 2;
  localparam int LINK_W   = $clog2(NODES);

  typedef struct {
    logic              status;
    logic [DATA_W-1:0] elem;
    logic              is_empty;
    logic              last;
    logic [CNT_W-1:0]  count;
  } list_result_t;

  logic [LINK_W-1:0] link_tab [NODES];
  logic [DATA_W-1:0] value_tab [NODES];
  int unsigned       list_len;
  list_result_t      due_q [$];

  // free head leads to the chain 1..NODES-2, the data head ends its chain
  function automatic void clear_tables();
    for (int k = 0; k < NODES; k++) begin
      link_tab[k]  = LINK_W'(k + 1);
      value_tab[k] = '0;
    end
    link_tab[NODES-2] = '0;
    link_tab[HEAD]    = '0;
    list_len          = 0;
  endfunction

  function automatic void push_result(logic status, logic [DATA_W-1:0] elem,
                                      logic is_empty, logic last);
    list_result_t r;
    r.status   = status;
    r.elem     = elem;
    r.is_empty = is_empty;
    r.last     = last;
    r.count    = CNT_W'(list_len);
    due_q.push_back(r);
  endfunction

  // node that precedes the element at a 1-based position
  function automatic int unsigned node_before(int unsigned pos);
    int unsigned node;
    node = HEAD;
    for (int unsigned s = 1; s < pos; s++) node = 32'(link_tab[node]);
    return node;
  endfunction

  function automatic void apply_command(logic [CMD_W-1:0] cmd, int unsigned pos,
                                        logic [DATA_W-1:0] val);
    int unsigned fresh;
    int unsigned prev;
    int unsigned gone;
    int unsigned node;
    int unsigned nxt;
    int unsigned n;
    logic        fin;
    case (cmd)
      CMD_INSERT: begin
        fresh = 32'(link_tab[0]);
        if (pos < 1 || pos > list_len + 1 || list_len >= CAPACITY ||
            fresh == 0 || fresh >= HEAD) begin
          push_result(1'b1, '0, 1'b0, 1'b1);
        end else begin
          link_tab[0]      = link_tab[fresh];
          value_tab[fresh] = val;
          prev             = node_before(pos);
          link_tab[fresh]  = link_tab[prev];
          link_tab[prev]   = LINK_W'(fresh);
          list_len++;
          push_result(1'b0, '0, 1'b0, 1'b1);
        end
      end
      CMD_DELETE: begin
        if (pos < 1 || pos > list_len) begin
          push_result(1'b1, '0, 1'b0, 1'b1);
        end else begin
          prev = node_before(pos);
          gone = 32'(link_tab[prev]);
          if (gone == 0 || gone >= HEAD) begin
            push_result(1'b1, '0, 1'b0, 1'b1);
          end else begin
            link_tab[prev] = link_tab[gone];
            link_tab[gone] = link_tab[0];
            link_tab[0]    = LINK_W'(gone);
            list_len--;
            push_result(1'b0, '0, 1'b0, 1'b1);
          end
        end
      end
      CMD_TRAVERSE: begin
        node = 32'(link_tab[HEAD]);
        if (list_len == 0 || node == 0) begin
          push_result(1'b0, '0, 1'b1, 1'b1);
        end else begin
          n   = 0;
          fin = 1'b0;
          while (!fin && node != 0 && n < list_len) begin
            nxt = 32'(link_tab[node]);
            fin = (nxt == 0) || (n + 1 >= list_len);
            push_result(1'b0, value_tab[node], 1'b0, fin);
            n++;
            node = nxt;
          end
        end
      end
      default: push_result(1'b1, '0, 1'b0, 1'b1);
    endcase
  endfunction

  function automatic void check_field(string name, logic [DATA_W-1:0] want,
                                      logic [DATA_W-1:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected %0h, actual %0h", name, want, got);
      fail_count++;
    end
  endfunction

  always @(posedge clk) begin
    list_result_t want;
    if (!rst_n) begin
      clear_tables();
      due_q.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        if (due_q.size() == 0) begin
          $error("result with no expectation: tdata %0h tlast %0b", out_tdata, out_tlast);
          fail_count++;
        end else begin
          want = due_q.pop_front();
          check_field("status", 32'(want.status), 32'(out_tdata[0]));
          check_field("elem", want.elem, out_tdata[32:1]);
          check_field("is_empty", 32'(want.is_empty), 32'(out_tdata[33]));
          check_field("last", 32'(want.last), 32'(out_tlast));
          check_field("count", 32'(want.count), 32'(out_tdata[39:34]));
        end
      end
      if (in_tvalid && in_tready)
        apply_command(in_tuser, 32'(in_tdata[5:0]), in_tdata[37:6]);
    end
    pending <= due_q.size();
  end

endmodule

FILE: sim/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives insert, delete and traverse commands into the linked list engine
// with bursty input and a stalling output, and reports the checker's verdict.
// ----------------------------------------------------------------------------
module testbench;
  import sll_pkg::*;

  localparam int NODES      = 32;
  localparam int CAPACITY   = NODES - 2;
  localparam int IDLE_LIMIT = 2000;  // cycles with no item moving on either side
  localparam int DRAIN_WAIT = 80;    // quiet spell after the last predicted result

  // command code the block does not define, answered with an error
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [39:0] in_tdata   = '0;   // position[5:0], value[37:6], zero pad[39:38]
  logic [1:0]  in_tuser   = '0;   // cmd[1:0]
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [39:0] out_tdata;         // status[0], elem[32:1], is_empty[33], count[39:34]
  logic        out_tlast;

  int fail_count;
  int pending;

  // stimulus side: length of the list as the commands so far leave it,
  // used only to aim positions at valid places
  int unsigned shadow_len  = 0;
  int unsigned burst_left  = 0;
  int unsigned idle_cycles = 0;

  // receiver stall pattern state
  int unsigned rx_mode  = 0;
  int unsigned rx_timer = 0;
  int unsigned rx_phase = 0;
  int unsigned rx_hold  = 0;

  static_linked_list_engine_top #(.NODES(NODES)) uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  sll_checker #(.NODES(NODES)) list_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // one item on the command stream; gaps open only between bursts so that
  // in_tvalid never drops and rises within one step
  task automatic send_cmd(logic [CMD_W-1:0] cmd, logic [POS_W-1:0] pos,
                          logic [DATA_W-1:0] val);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 12);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= {2'b00, val, pos};
    do @(posedge clk); while (!in_tready);
    burst_left--;
    // keep the aiming length in step with what the block will do
    if (cmd == CMD_INSERT && pos >= 1 && pos <= shadow_len + 1 && shadow_len < CAPACITY)
      shadow_len++;
    else if (cmd == CMD_DELETE && pos >= 1 && pos <= shadow_len)
      shadow_len--;
  endtask

  // half the time an end of the list, otherwise anywhere in range
  function automatic logic [POS_W-1:0] aim_pos(int unsigned top);
    case ($urandom_range(0, 3))
      0:       return POS_W'(1);
      1:       return POS_W'(top);
      default: return POS_W'($urandom_range(1, top));
    endcase
  endfunction

  // receiver: a new stall pattern each time its timer runs out
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (rx_timer == 0) begin
        rx_mode  = $urandom_range(0, 3);
        rx_timer = $urandom_range(20, 80);
      end else begin
        rx_timer--;
      end
      rx_phase++;
      case (rx_mode)
        0: out_tready <= 1'b1;                          // no stalls at all
        1: out_tready <= (rx_phase % 3) != 0;           // regular one-in-three
        2: out_tready <= $urandom_range(0, 9) < 6;      // random stalls
        default: begin                                  // long stalls and runs
          if (rx_hold == 0) begin
            rx_hold = $urandom_range(1, 8);
            out_tready <= !out_tready;
          end else begin
            rx_hold--;
          end
        end
      endcase
    end
  end

  // watchdog: ends a run in which nothing moves for too long
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  initial begin
    int i;
    int pick;
    bit grow;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // directed: empty list, bad positions, inserts at head, middle and tail,
    // deletes at head and tail, extreme values, the undefined command code
    send_cmd(CMD_TRAVERSE, 6'd0, 32'h0);
    send_cmd(CMD_DELETE, 6'd1, 32'h0);
    send_cmd(CMD_INSERT, 6'd0, 32'h1234_5678);
    send_cmd(CMD_INSERT, 6'd2, 32'h1234_5678);
    send_cmd(CMD_INSERT, 6'd1, 32'h7FFF_FFFF);
    send_cmd(CMD_INSERT, 6'd2, 32'h8000_0000);
    send_cmd(CMD_INSERT, 6'd1, 32'hFFFF_FFFF);
    send_cmd(CMD_INSERT, 6'd2, 32'h0000_0000);
    send_cmd(CMD_INSERT, 6'd63, 32'hA5A5_A5A5);
    send_cmd(CMD_TRAVERSE, 6'd63, 32'hFFFF_FFFF);
    send_cmd(CMD_DELETE, 6'd5, 32'h0);
    send_cmd(CMD_DELETE, 6'd0, 32'h0);
    send_cmd(CMD_DELETE, 6'd63, 32'hFFFF_FFFF);
    send_cmd(CMD_DELETE, 6'd4, 32'h0);
    send_cmd(CMD_DELETE, 6'd1, 32'h0);
    send_cmd(CMD_UNUSED, 6'd1, 32'h5A5A_5A5A);
    send_cmd(CMD_TRAVERSE, 6'd0, 32'h0);
    send_cmd(CMD_INSERT, 6'd3, 32'h0000_0001);
    send_cmd(CMD_TRAVERSE, 6'd0, 32'h0);

    // random: alternating grow and shrink phases of well-formed commands,
    // two runs that fill the store and push past it, some noise
    for (i = 0; i < 80; i++) begin
      grow = ((i / 20) % 2) == 0;
      pick = $urandom_range(0, 99);
      if (i == 30 || i == 70) begin
        while (shadow_len < CAPACITY)
          send_cmd(CMD_INSERT, aim_pos(shadow_len + 1), $urandom);
        // store full: a well-placed insert still fails
        send_cmd(CMD_INSERT, aim_pos(shadow_len + 1), $urandom);
        send_cmd(CMD_TRAVERSE, POS_W'($urandom), $urandom);
      end else if (pick < 12) begin
        send_cmd(CMD_W'($urandom_range(0, 2)), POS_W'($urandom_range(0, 63)), $urandom);
      end else if (pick < 22) begin
        send_cmd(CMD_TRAVERSE, POS_W'($urandom), $urandom);
      end else if (pick < (grow ? 75 : 40) || shadow_len == 0) begin
        send_cmd(CMD_INSERT, aim_pos(shadow_len + 1), $urandom);
      end else begin
        send_cmd(CMD_DELETE, aim_pos(shadow_len), $urandom);
      end
    end
    in_tvalid <= 1'b0;

    // drain: every predicted result back, then a quiet spell for strays
    do @(posedge clk); while (pending != 0);
    repeat (DRAIN_WAIT) @(posedge clk);

    if (fail_count == 0 && pending == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
